// ----- hdl/adc_burst_window_averager_top_defines.svh -----
// ----------------------------------------------------------------------------
// ADC burst window averager: assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ADC_BURST_WINDOW_AVERAGER_TOP_DEFINES_SVH
`define ADC_BURST_WINDOW_AVERAGER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABWA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abwa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ABWA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abwa assertion failed");

`endif

// ----- hdl/abwa_pkg.sv -----
// ----------------------------------------------------------------------------
// abwa_pkg
// Types and constants shared by the ADC burst window averager modules.
// ----------------------------------------------------------------------------
package abwa_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 26;
  localparam int TOTAL_W  = 30;
  localparam int POS_W    = 10;
  localparam int SPB_W    = 11;
  localparam int LEN_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Window store geometry and the adder tree split
  localparam int WIN_DEPTH = 16;
  localparam int GROUP_N   = 4;
  localparam int GROUP_SZ  = WIN_DEPTH / GROUP_N;
  localparam int PART_W    = ACC_W + 2;

  // Limits and reset values
  localparam logic [SPB_W-1:0]    BURST_MAX     = 11'd1024;
  localparam logic [LEN_W-1:0]    WIN_LEN_MAX   = 5'd16;
  localparam logic [SPB_W-1:0]    SPB_RESET     = 11'd50;
  localparam logic [LEN_W-1:0]    WLEN_RESET    = 5'd4;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BURST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 1'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clear_request;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] window_total;
    logic               under_range;
    logic               over_range;
    logic               range_error;
  } out_item_t;

  typedef struct packed {
    logic [SPB_W-1:0] samples_per_burst;
    logic [LEN_W-1:0] window_length;
  } cfg_t;

  // Burst-end event handed from the front end to the summing pipeline
  typedef struct packed {
    logic             under;
    logic             over;
    logic [LEN_W-1:0] len;
  } burst_evt_t;

  typedef logic [WIN_DEPTH-1:0][ACC_W-1:0] win_arr_t;
  typedef logic [GROUP_N-1:0][PART_W-1:0]  part_arr_t;

endpackage

// ----- hdl/abwa_front.sv -----
// ----------------------------------------------------------------------------
// abwa_front
// Burst accumulation, range flags, clear request and window store update.
// ----------------------------------------------------------------------------
`include "adc_burst_window_averager_top_defines.svh"

module abwa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abwa_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  abwa_pkg::in_item_t   in_data,
  input  logic                 evt_take,
  output logic                 evt_valid,
  output abwa_pkg::burst_evt_t evt,
  output abwa_pkg::win_arr_t   store
);

  logic [abwa_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [abwa_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                        zero_r, zero_nxt;
  logic                        full_r, full_nxt;
  logic                        pend_r, pend_nxt;
  logic [abwa_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  abwa_pkg::win_arr_t          store_r, store_nxt;
  logic                        ev_r, ev_nxt;
  abwa_pkg::burst_evt_t        evt_r, evt_nxt;

  logic                        accept;
  logic [abwa_pkg::SPB_W-1:0]  burst_len;
  logic [abwa_pkg::LEN_W-1:0]  win_len;
  logic [abwa_pkg::SPB_W-1:0]  pos_inc;
  logic                        burst_end;
  logic [abwa_pkg::ACC_W-1:0]  acc_sum;
  logic                        zero_now, full_now;
  logic                        refill;
  logic [abwa_pkg::SLOT_W-1:0] slot_sel;

  // One event slot; a new item waits only while that slot is stuck
  assign in_ready = !ev_r || evt_take;
  assign accept   = in_valid && in_ready;

  // Effective burst and window lengths
  always_comb begin
    if (cfg.samples_per_burst == '0) begin
      burst_len = abwa_pkg::SPB_W'(1);
    end else if (cfg.samples_per_burst > abwa_pkg::BURST_MAX) begin
      burst_len = abwa_pkg::BURST_MAX;
    end else begin
      burst_len = cfg.samples_per_burst;
    end
    if (cfg.window_length == '0) begin
      win_len = abwa_pkg::LEN_W'(1);
    end else if (cfg.window_length > abwa_pkg::WIN_LEN_MAX) begin
      win_len = abwa_pkg::WIN_LEN_MAX;
    end else begin
      win_len = cfg.window_length;
    end
  end

  // Per-sample terms
  assign pos_inc   = {1'b0, pos_r} + abwa_pkg::SPB_W'(1);
  assign burst_end = (pos_inc >= burst_len);
  assign acc_sum   = acc_r + abwa_pkg::ACC_W'(in_data.sample);
  assign zero_now  = (in_data.sample == '0);
  assign full_now  = (in_data.sample == abwa_pkg::FULL_SCALE);
  assign refill    = pend_r || in_data.clear_request;
  assign slot_sel  = ({1'b0, slot_r} >= win_len) ? '0 : slot_r;

  // Next state
  always_comb begin
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    zero_nxt  = zero_r;
    full_nxt  = full_r;
    pend_nxt  = pend_r;
    slot_nxt  = slot_r;
    store_nxt = store_r;
    evt_nxt   = evt_r;
    ev_nxt    = ev_r && !evt_take;
    if (accept) begin
      if (burst_end) begin
        acc_nxt  = '0;
        pos_nxt  = '0;
        zero_nxt = 1'b0;
        full_nxt = 1'b0;
        pend_nxt = 1'b0;
        slot_nxt = slot_sel + abwa_pkg::SLOT_W'(1);
        for (int k = 0; k < abwa_pkg::WIN_DEPTH; k++) begin
          if (refill ? (abwa_pkg::LEN_W'(k) < win_len)
                     : (abwa_pkg::SLOT_W'(k) == slot_sel)) begin
            store_nxt[k] = acc_sum;
          end
        end
        evt_nxt.under = zero_r || zero_now;
        evt_nxt.over  = (full_r || full_now) && !(zero_r || zero_now);
        evt_nxt.len   = win_len;
        ev_nxt        = 1'b1;
      end else begin
        acc_nxt  = acc_sum;
        pos_nxt  = pos_inc[abwa_pkg::POS_W-1:0];
        zero_nxt = zero_r || zero_now;
        full_nxt = full_r || full_now;
        pend_nxt = refill;
      end
    end
  end

  // State registers; the window store resets to all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      pos_r   <= '0;
      zero_r  <= 1'b0;
      full_r  <= 1'b0;
      pend_r  <= 1'b0;
      slot_r  <= '0;
      store_r <= '0;
      ev_r    <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      zero_r  <= zero_nxt;
      full_r  <= full_nxt;
      pend_r  <= pend_nxt;
      slot_r  <= slot_nxt;
      store_r <= store_nxt;
      ev_r    <= ev_nxt;
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    evt_r <= evt_nxt;
  end

  assign evt_valid = ev_r;
  assign evt       = evt_r;
  assign store     = store_r;

  // Checks
  `ABWA_ASSERT_NOW(a_flags_excl, ev_r, !(evt_r.under && evt_r.over))
  `ABWA_ASSERT_NOW(a_len_range, ev_r, (evt_r.len != '0) && (evt_r.len <= abwa_pkg::WIN_LEN_MAX))
  `ABWA_ASSERT_NEXT(a_evt_hold, ev_r && !evt_take, ev_r && $stable(evt_r) && $stable(store_r))
  `ABWA_ASSERT_NEXT(a_burst_restart, accept && burst_end, (acc_r == '0) && (pos_r == '0) && !pend_r)

endmodule

// ----- hdl/abwa_sum.sv -----
// ----------------------------------------------------------------------------
// abwa_sum
// Two-stage registered adder tree over the active window entries.
// ----------------------------------------------------------------------------
module abwa_sum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 evt_valid,
  output logic                 evt_take,
  input  abwa_pkg::burst_evt_t evt,
  input  abwa_pkg::win_arr_t   store,
  output logic                 out_valid,
  input  logic                 out_ready,
  output abwa_pkg::out_item_t  out_data
);

  logic                 a_v_r, a_v_nxt;
  abwa_pkg::part_arr_t  part_r, part_nxt;
  logic                 a_under_r, a_over_r;
  logic                 o_v_r, o_v_nxt;
  abwa_pkg::out_item_t  out_r, out_nxt;

  logic                 out_take;
  logic                 a_take;
  abwa_pkg::win_arr_t   masked;
  logic [abwa_pkg::TOTAL_W-1:0] total;

  // Each stage moves when the one after it is empty or moving
  assign out_take = !o_v_r || out_ready;
  assign a_take   = !a_v_r || out_take;
  assign evt_take = a_take;

  // Stage A: mask entries beyond the window, sum groups of four
  always_comb begin
    for (int k = 0; k < abwa_pkg::WIN_DEPTH; k++) begin
      masked[k] = (abwa_pkg::LEN_W'(k) < evt.len) ? store[k] : '0;
    end
    for (int g = 0; g < abwa_pkg::GROUP_N; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < abwa_pkg::GROUP_SZ; j++) begin
        part_nxt[g] = part_nxt[g]
                    + abwa_pkg::PART_W'(masked[g*abwa_pkg::GROUP_SZ + j]);
      end
    end
  end

  // Output stage: final sum of the group partials
  always_comb begin
    total = '0;
    for (int g = 0; g < abwa_pkg::GROUP_N; g++) begin
      total = total + abwa_pkg::TOTAL_W'(part_r[g]);
    end
    out_nxt.window_total = total;
    out_nxt.under_range  = a_under_r;
    out_nxt.over_range   = a_over_r;
    out_nxt.range_error  = a_under_r || a_over_r;
  end

  always_comb begin
    a_v_nxt = a_take ? evt_valid : a_v_r;
    o_v_nxt = out_take ? a_v_r : o_v_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (a_take) begin
      part_r    <= part_nxt;
      a_under_r <= evt.under;
      a_over_r  <= evt.over;
    end
    if (out_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/adc_burst_window_averager_top.sv -----
// ----------------------------------------------------------------------------
// adc_burst_window_averager_top
// One-channel ADC oversampling accumulator with a moving window of bursts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw 16-bit sample per transfer plus a clear request bit.
//   out_* : one result per completed burst: window total and range flags.
//   cfg_* : write-only registers (samples_per_burst, window_length), written
//           with cfg_we; change them only while no burst result is in flight.
// Throughput: one sample per cycle, including a burst end on every sample,
//   while out_ready stays high. A burst-ending sample passes the event
//   register and then the two-level registered adder tree (16 entries to 4
//   partials, then to one total) before it shows on out_valid.
// Reset (rst_n low, synchronous): registers return to 50 and 4, the window
//   store, burst sum, flags, pending clear and slot all clear to zero.
// Stall: while out_ready is low the tree keeps collapsing bubbles; samples
//   that end no burst keep flowing until all three result slots are full,
//   then in_ready drops until the receiver takes a transfer.
// ----------------------------------------------------------------------------
module adc_burst_window_averager_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  abwa_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output abwa_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [abwa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abwa_pkg::CFG_W-1:0]        cfg_wdata
);

  abwa_pkg::cfg_t       cfg_r, cfg_nxt;
  logic                 evt_valid;
  logic                 evt_take;
  abwa_pkg::burst_evt_t evt;
  abwa_pkg::win_arr_t   store;

  // Configuration register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        abwa_pkg::REG_SAMPLES_PER_BURST:
          cfg_nxt.samples_per_burst = cfg_wdata[abwa_pkg::SPB_W-1:0];
        abwa_pkg::REG_WINDOW_LENGTH:
          cfg_nxt.window_length = cfg_wdata[abwa_pkg::LEN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_burst <= abwa_pkg::SPB_RESET;
      cfg_r.window_length     <= abwa_pkg::WLEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Burst accumulation and window store
  abwa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .evt_take  (evt_take),
    .evt_valid (evt_valid),
    .evt       (evt),
    .store     (store)
  );

  // Window total pipeline and output register
  abwa_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_take  (evt_take),
    .evt       (evt),
    .store     (store),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_adc_burst_window_averager_top.sv -----
// ----------------------------------------------------------------------------
// tb_adc_burst_window_averager_top
// Self-checking bench for the one-channel burst window averager. A short
// stimulus table covers reset values, range flags, window refills and the
// clamped register settings. Random phases follow, mostly under new register
// values, with idle bursts on both channels. A long output stall backs the
// pipe up into the sample input. Every window result is checked against an
// in-bench model of burst sum, moving window and flags, or a table value.
// ----------------------------------------------------------------------------
module tb_adc_burst_window_averager_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abwa_pkg::*;

  localparam int SETTLE_CYCLES = 8;       // drain margin after the owed results
  localparam int LONG_HOLD     = 80;      // long output stall, in cycles
  localparam int CYCLE_LIMIT   = 400000;

  // Directed table row: a register write, or a sample with an optional
  // hand-computed result
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Window model state
  logic [SPB_W-1:0] cur_spb;
  logic [LEN_W-1:0] cur_wlen;
  logic [ACC_W-1:0] burst_sum;
  int               taken;
  bit               saw_zero;
  bit               saw_full;
  bit               refill_armed;
  logic [ACC_W-1:0] win_mem [WIN_DEPTH];
  int               wr_slot;

  out_item_t owed_results[$];
  plan_row_t plan[$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        hold_req    = 0;
  int        hold_done   = 0;
  bit        quiet_tail  = 1'b0;

  adc_burst_window_averager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Window model
  // --------------------------------------------------------------------------
  task automatic clear_model();
    cur_spb      = SPB_RESET;
    cur_wlen     = WLEN_RESET;
    burst_sum    = '0;
    taken        = 0;
    saw_zero     = 1'b0;
    saw_full     = 1'b0;
    refill_armed = 1'b0;
    wr_slot      = 0;
    for (int k = 0; k < WIN_DEPTH; k++) win_mem[k] = '0;
  endtask

  // Folds one sample into the burst; returns a result when the burst closes
  task automatic accumulate_sample(input in_item_t it, output bit done,
                                   output out_item_t res);
    int          burst_len;
    int          win_len;
    logic [63:0] total;
    done = 1'b0;
    res  = '0;
    if (it.clear_request) refill_armed = 1'b1;
    if (it.sample == '0) saw_zero = 1'b1;
    else if (it.sample == FULL_SCALE) saw_full = 1'b1;
    burst_sum = burst_sum + ACC_W'(it.sample);
    taken++;

    // zero acts as one, anything above the max is clamped
    burst_len = (cur_spb == '0) ? 1 : (cur_spb > BURST_MAX) ? int'(BURST_MAX) : int'(cur_spb);
    if (taken < burst_len) return;

    win_len = (cur_wlen == '0) ? 1 : (cur_wlen > WIN_LEN_MAX) ? int'(WIN_LEN_MAX) :
              int'(cur_wlen);
    if (wr_slot >= win_len) wr_slot = 0;
    if (refill_armed) begin
      for (int k = 0; k < win_len; k++) win_mem[k] = burst_sum;
      refill_armed = 1'b0;
    end else begin
      win_mem[wr_slot] = burst_sum;
    end
    wr_slot++;

    total = '0;
    for (int k = 0; k < win_len; k++) total += 64'(win_mem[k]);
    res.window_total = total[TOTAL_W-1:0];
    res.under_range  = saw_zero;
    res.over_range   = saw_full && !saw_zero;
    res.range_error  = saw_zero || saw_full;
    done = 1'b1;

    burst_sum = '0;
    taken     = 0;
    saw_zero  = 1'b0;
    saw_full  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driving; called and returning at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_sample(input in_item_t it, input bit gaps, input bit typed,
                             input out_item_t want);
    bit        done;
    out_item_t res;
    if (gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    accumulate_sample(it, done, res);
    if (done) owed_results.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Stop offering samples and let every owed result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_SAMPLES_PER_BURST) cur_spb = val[SPB_W-1:0];
    else cur_wlen = val[LEN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) it.sample = '0;
    else if (pick < 8) it.sample = FULL_SCALE;
    else if (pick < 12) it.sample = SAMPLE_W'($urandom_range(1, 15));
    else if (pick < 16) it.sample = FULL_SCALE - SAMPLE_W'($urandom_range(1, 15));
    else it.sample = SAMPLE_W'($urandom);
    it.clear_request = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  task automatic run_phase(input int n, input bit gaps);
    for (int i = 0; i < n; i++) send_sample(random_item(), gaps, 1'b0, '0);
  endtask

  // Table builders
  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = CFG_W'(val);
    plan.push_back(r);
  endtask

  task automatic add_smp(input logic [SAMPLE_W-1:0] s, input logic clr);
    plan_row_t r;
    r                    = '{default: '0};
    r.item.sample        = s;
    r.item.clear_request = clr;
    plan.push_back(r);
  endtask

  task automatic add_chk(input logic [SAMPLE_W-1:0] s, input logic clr,
                         input logic [TOTAL_W-1:0] tot, input logic u, input logic o,
                         input logic e);
    plan_row_t r;
    r                    = '{default: '0};
    r.item.sample        = s;
    r.item.clear_request = clr;
    r.typed              = 1'b1;
    r.want               = '{window_total: tot, under_range: u, over_range: o,
                             range_error: e};
    plan.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done++;
        out_ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report(input string why, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: exp total=%0d ur=%0b or=%0b err=%0b, got total=%0d ur=%0b or=%0b err=%0b",
               $realtime, why, want.window_total, want.under_range, want.over_range,
               want.range_error, got.window_total, got.under_range, got.over_range,
               got.range_error);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        report("result with nothing owed", '0, out_data);
      end else begin
        want = owed_results.pop_front();
        if (out_data.window_total !== want.window_total ||
            out_data.under_range !== want.under_range ||
            out_data.over_range !== want.over_range ||
            out_data.range_error !== want.range_error)
          report("window result mismatch", want, out_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    clear_model();

    // Reset values are checked by the first rows: 50-sample bursts, 4-deep window
    add_smp(16'h0000, 1'b0);
    add_smp(16'hFFFF, 1'b0);
    add_smp(16'h0001, 1'b0);
    // burst length lowered below the count already taken
    add_cfg(REG_SAMPLES_PER_BURST, 2);
    add_chk(16'h8000, 1'b0, 30'd98304, 1'b1, 1'b0, 1'b1);
    add_smp(16'hFFFF, 1'b1);
    add_chk(16'h7FFF, 1'b0, 30'd393208, 1'b0, 1'b1, 1'b1);
    // zero burst length acts as one; clear on the burst-ending sample
    add_cfg(REG_SAMPLES_PER_BURST, 0);
    add_chk(16'hFFFF, 1'b1, 30'd262140, 1'b0, 1'b1, 1'b1);
    // zero window acts as one, slot falls outside and wraps to zero
    add_cfg(REG_WINDOW_LENGTH, 0);
    add_chk(16'h1234, 1'b0, 30'd4660, 1'b0, 1'b0, 1'b0);
    // overlong window clamps to full depth
    add_cfg(REG_WINDOW_LENGTH, 31);
    add_chk(16'h0000, 1'b0, 30'd135730, 1'b1, 1'b0, 1'b1);
    add_smp(16'hA5A5, 1'b1);
    // clear latched mid-burst, refill at burst end
    add_cfg(REG_SAMPLES_PER_BURST, 3);
    add_smp(16'h5A5A, 1'b1);
    add_smp(16'h0001, 1'b0);
    add_smp(16'hFFFE, 1'b1);
    add_cfg(REG_WINDOW_LENGTH, 16);
    add_smp(16'h8001, 1'b0);
    add_smp(16'h7FFE, 1'b0);
    add_smp(16'hFFFF, 1'b0);
    // zero and full scale in one burst: under-range wins
    add_cfg(REG_WINDOW_LENGTH, 1);
    add_smp(16'h0000, 1'b0);
    add_smp(16'hFFFF, 1'b0);
    add_chk(16'hFFFF, 1'b0, 30'd131070, 1'b1, 1'b0, 1'b1);

    // Synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_sample(plan[i].item, 1'b1, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: mostly short bursts, clamped values now and then
    for (int p = 0; p < 12; p++) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_SAMPLES_PER_BURST, '0);
          1:       write_reg(REG_SAMPLES_PER_BURST, CFG_W'($urandom_range(9, 24)));
          default: write_reg(REG_SAMPLES_PER_BURST, CFG_W'($urandom_range(1, 6)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_WINDOW_LENGTH, '0);
          1:       write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(17, 31)));
          2:       write_reg(REG_WINDOW_LENGTH, CFG_W'(WIN_LEN_MAX));
          default: write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(1, 15)));
        endcase
      end
      run_phase($urandom_range(35, 65), $urandom_range(0, 3) != 0);
    end

    // Every sample closes a burst while the receiver holds off: input backs up
    settle();
    write_reg(REG_SAMPLES_PER_BURST, 1);
    write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(1, 16)));
    hold_req++;
    run_phase(40, 1'b0);

    // Longest burst: start at the max, then finish it under an overlong value
    settle();
    write_reg(REG_SAMPLES_PER_BURST, CFG_W'(BURST_MAX));
    write_reg(REG_WINDOW_LENGTH, CFG_W'(WIN_LEN_MAX));
    run_phase(300, 1'b1);
    settle();
    write_reg(REG_SAMPLES_PER_BURST, 11'h7FF);
    run_phase(730, 1'b1);

    // Tail at full rate, no stalls on either side
    settle();
    quiet_tail = 1'b1;
    write_reg(REG_SAMPLES_PER_BURST, CFG_W'($urandom_range(1, 4)));
    write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(1, 16)));
    run_phase(100, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/abwa_pkg.sv
hdl/abwa_front.sv
hdl/abwa_sum.sv
hdl/adc_burst_window_averager_top.sv
tb/tb_adc_burst_window_averager_top.sv
